// ----- rtl/two_ended_bitmap_id_allocator_defines.svh -----
// assertion macros used by the checker file
`ifndef TWO_ENDED_BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define TWO_ENDED_BITMAP_ID_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TEBIA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tebia assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TEBIA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tebia assertion failed");

`endif

// ----- rtl/tebia_pkg.sv -----
package tebia_pkg;

	localparam int ID_COUNT     = 256;
	localparam int WINDOW_VIEWS = 32;

	localparam int ID_W   = 8;
	localparam int WORD_W = 32;
	localparam int OFF_W  = $clog2(WORD_W);
	localparam int ROWS   = (ID_COUNT + WORD_W - 1) / WORD_W;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

	// 255 is the none marker, so scans never reach it
	localparam int SCAN_TOP     = ((ID_COUNT - 1) < 254) ? (ID_COUNT - 1) : 254;
	localparam int TOP_ROW      = SCAN_TOP / WORD_W;
	localparam int WINDOW_FLOOR = ID_COUNT - 1 - WINDOW_VIEWS;

	localparam logic [ID_W-1:0] NONE_ID     = 8'd255;
	localparam logic [ID_W-1:0] SCAN_TOP_ID = ID_W'(SCAN_TOP);
	localparam logic [ID_W-1:0] WHINT_RESET = 8'd254;

	typedef enum logic [1:0] {
		OP_ALLOC_NORMAL = 2'd0,
		OP_ALLOC_WINDOW = 2'd1,
		OP_RELEASE      = 2'd2,
		OP_NOP          = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             found;
		logic [OFF_W-1:0] off;
	} scan_res_t;

endpackage

// ----- rtl/tebia_ram.sv -----
module tebia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/tebia_word_scan.sv -----
module tebia_word_scan
	import tebia_pkg::*;
(
	input  logic [WORD_W-1:0] word,
	input  logic [OFF_W-1:0]  lo,
	input  logic [OFF_W-1:0]  hi,
	input  logic              down,
	output scan_res_t         res
);

	logic [WORD_W-1:0] rng;
	logic [WORD_W-1:0] cand;
	logic [WORD_W-1:0] ord;
	logic [WORD_W-1:0] iso;
	logic [OFF_W-1:0]  enc;

	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			rng[i] = (OFF_W'(i) >= lo) && (OFF_W'(i) <= hi);
		end
		cand = ~word & rng;
		// a downward search is an upward one on the mirrored word
		for (int i = 0; i < WORD_W; i++) begin
			ord[i] = down ? cand[WORD_W-1-i] : cand[i];
		end
		iso = ord & (~ord + WORD_W'(1));
		enc = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (iso[i]) begin
				enc = enc | OFF_W'(i);
			end
		end
		res.found = |cand;
		res.off   = down ? (OFF_W'(WORD_W - 1) - enc) : enc;
	end

endmodule

// ----- rtl/two_ended_bitmap_id_allocator.sv -----
// channel  | signals                          | role
// in       | in_valid in_ready op release_id  | one command word per op
// out      | out_valid out_ready granted_id   | one result word per command
//          | none_free                        |
// the used map sits in a 32-bit wide ram, one row per 32 ids, read one row a cycle
// allocation: read the start row, then scan row by row to a free id or the end row of its direction
// release: read, modify, write back; nop and hopeless scans skip the ram
// reset clears a per-row valid bit, so the map reads as all free at once
// a result waiting on out_ready holds the block in its done state
module two_ended_bitmap_id_allocator
	import tebia_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      op,
	input  logic [ID_W-1:0] release_id,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [ID_W-1:0] granted_id,
	output logic            none_free
);

	state_t state_q, state_d;

	op_t              in_op, op_q;
	logic [ID_W-1:0]  id_q;
	logic [ROW_W-1:0] row_q;
	logic [ID_W-1:0]  nhint_q, whint_q;
	logic [ROWS-1:0]  vld_q;
	logic             rd_vld_s1;
	logic [ID_W-1:0]  res_gid_q;
	logic             res_nf_q;
	logic             out_valid_q;
	logic [ID_W-1:0]  gid_q;
	logic             nf_q;

	logic             acc;
	logic [ID_W-1:0]  dstart;
	logic             rel_ok;
	logic             go_read;
	logic [ROW_W-1:0] start_row;
	logic [ROW_W-1:0] nhint_row, dstart_row;

	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] word;
	logic [OFF_W-1:0]  lo, hi;
	logic              down;
	scan_res_t         sr;
	logic [OFF_W-1:0]  sel_off;
	logic [WORD_W-1:0] sel;
	logic              is_rel;
	logic              last_row;
	logic              eval_done;
	logic [ROW_W-1:0]  row_nxt;
	logic [ID_W-1:0]   found_id;
	logic              out_free;

	logic              ram_re, ram_we;
	logic [ROW_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              set_res;
	logic [ID_W-1:0]   res_gid_d;
	logic              res_nf_d;
	logic              hint_we;

	assign in_op    = op_t'(op);
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// command decode at accept
	always_comb begin
		dstart    = (whint_q > SCAN_TOP_ID) ? SCAN_TOP_ID : whint_q;
		rel_ok    = (release_id != NONE_ID) && ({1'b0, release_id} < 9'(ID_COUNT));
		nhint_row = ROW_W'(nhint_q >> OFF_W);
		dstart_row = ROW_W'(dstart >> OFF_W);
		unique case (in_op)
			OP_ALLOC_NORMAL: begin
				start_row = nhint_row;
				go_read   = (nhint_q <= SCAN_TOP_ID);
			end
			OP_ALLOC_WINDOW: begin
				start_row = dstart_row;
				go_read   = 1'b1;
			end
			OP_RELEASE: begin
				start_row = ROW_W'(release_id >> OFF_W);
				go_read   = rel_ok;
			end
			OP_NOP: begin
				start_row = '0;
				go_read   = 1'b0;
			end
		endcase
	end

	// row search and modify
	always_comb begin
		word   = rd_vld_s1 ? rdata : '0;
		is_rel = (op_q == OP_RELEASE);
		down   = (op_q == OP_ALLOC_WINDOW);
		if (down) begin
			lo = '0;
			hi = (row_q == dstart_row) ? dstart[OFF_W-1:0] : '1;
		end else begin
			lo = (row_q == nhint_row) ? nhint_q[OFF_W-1:0] : '0;
			hi = (row_q == ROW_W'(TOP_ROW)) ? SCAN_TOP_ID[OFF_W-1:0] : '1;
		end
		sel_off   = is_rel ? id_q[OFF_W-1:0] : sr.off;
		sel       = WORD_W'(1) << sel_off;
		last_row  = down ? (row_q == '0) : (row_q == ROW_W'(TOP_ROW));
		eval_done = is_rel || sr.found || last_row;
		row_nxt   = down ? (row_q - ROW_W'(1)) : (row_q + ROW_W'(1));
		found_id  = (ID_W'(row_q) << OFF_W) | ID_W'(sr.off);
	end

	tebia_word_scan u_scan (
		.word (word),
		.lo   (lo),
		.hi   (hi),
		.down (down),
		.res  (sr)
	);

	tebia_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = go_read ? ST_READ : ST_DONE;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				if (eval_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = row_q;
		ram_we    = 1'b0;
		ram_wdata = word | sel;
		set_res   = 1'b0;
		res_gid_d = '0;
		res_nf_d  = 1'b0;
		hint_we   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// no ram access: nop, release of nothing, normal hint past the top
				if (acc && !go_read) begin
					set_res  = 1'b1;
					res_nf_d = (in_op == OP_ALLOC_NORMAL);
				end
			end
			ST_READ: ram_re = 1'b1;
			ST_EVAL: begin
				if (is_rel) begin
					ram_we    = 1'b1;
					ram_wdata = word & ~sel;
					hint_we   = 1'b1;
					set_res   = 1'b1;
				end else if (sr.found) begin
					ram_we    = 1'b1;
					set_res   = 1'b1;
					res_gid_d = found_id;
				end else if (last_row) begin
					set_res  = 1'b1;
					res_nf_d = 1'b1;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = row_nxt;
				end
			end
			ST_DONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			nhint_q     <= '0;
			whint_q     <= WHINT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				vld_q[row_q] <= 1'b1;
			end
			if (hint_we) begin
				if (int'(id_q) > WINDOW_FLOOR) begin
					whint_q <= id_q;
				end else begin
					nhint_q <= id_q;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q  <= in_op;
			id_q  <= release_id;
			row_q <= start_row;
		end else if (ram_re && state_q == ST_EVAL) begin
			row_q <= row_nxt;
		end
		if (ram_re) begin
			rd_vld_s1 <= vld_q[ram_raddr];
		end
		if (set_res) begin
			res_gid_q <= res_gid_d;
			res_nf_q  <= res_nf_d;
		end
		if (state_q == ST_DONE && out_free) begin
			gid_q <= res_gid_q;
			nf_q  <= res_nf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign granted_id = gid_q;
	assign none_free  = nf_q;

endmodule

// ----- rtl/tebia_checker.sv -----
`include "two_ended_bitmap_id_allocator_defines.svh"

module tebia_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] op,
	input logic [7:0] release_id,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] granted_id,
	input logic       none_free
);

	// a result word waiting on the sink holds still
	`TEBIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(granted_id) && $stable(none_free))

	// one command in flight: accepting a word closes the input
	`TEBIA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// a failed scan grants nothing
	`TEBIA_ASSERT_NOW(a_fail_zero, out_valid && none_free, granted_id == 8'd0)

endmodule

bind two_ended_bitmap_id_allocator tebia_checker u_tebia_checker (.*);

// ----- tb/sv/testbench.sv -----
module testbench;
	import tebia_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_WORDS = 900;

	typedef struct {
		logic [ID_W-1:0] id;
		logic            exhausted;
	} grant_t;

	class alloc_tracker;
		logic [ID_COUNT-1:0] taken;
		logic [ID_W-1:0]     normal_hint;
		logic [ID_W-1:0]     window_hint;
		grant_t              expected_grants[$];
		int                  mismatches;

		function new();
			taken = '0;
			normal_hint = '0;
			window_hint = WHINT_RESET;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_grants.size();
		endfunction

		// random id that is currently handed out, any id up to SCAN_TOP if none is
		function logic [ID_W-1:0] pick_taken();
			int start;
			int idx;
			start = $urandom_range(SCAN_TOP);
			for (int k = 0; k <= SCAN_TOP; k++) begin
				idx = (start + k) % (SCAN_TOP + 1);
				if (taken[idx])
					return ID_W'(idx);
			end
			return ID_W'(start);
		endfunction

		function void note_word(op_t o, logic [ID_W-1:0] rid);
			grant_t g;
			int i;
			g.id = '0;
			g.exhausted = 1'b0;
			case (o)
				OP_ALLOC_NORMAL: begin
					g.exhausted = 1'b1;
					i = int'(normal_hint);
					while (i <= SCAN_TOP && g.exhausted) begin
						if (!taken[i]) begin
							taken[i] = 1'b1;
							g.id = ID_W'(i);
							g.exhausted = 1'b0;
						end
						i++;
					end
				end
				OP_ALLOC_WINDOW: begin
					g.exhausted = 1'b1;
					i = (int'(window_hint) > SCAN_TOP) ? SCAN_TOP : int'(window_hint);
					while (i >= 0 && g.exhausted) begin
						if (!taken[i]) begin
							taken[i] = 1'b1;
							g.id = ID_W'(i);
							g.exhausted = 1'b0;
						end
						i--;
					end
				end
				OP_RELEASE: if (rid != NONE_ID && int'(rid) < ID_COUNT) begin
					taken[rid] = 1'b0;
					// the top window ids steer the downward hint
					if (int'(rid) > WINDOW_FLOOR)
						window_hint = rid;
					else
						normal_hint = rid;
				end
				default: ;
			endcase
			expected_grants.insert(expected_grants.size(), g);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 40)
				$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_word(logic [ID_W-1:0] gid, logic nf);
			grant_t g;
			if (expected_grants.size() == 0) begin
				report_mismatch($sformatf("unexpected word granted_id %0d none_free %0b", gid, nf));
				return;
			end
			g = expected_grants.pop_front();
			if (gid !== g.id)
				report_mismatch($sformatf("granted_id %0d, predicted %0d", gid, g.id));
			if (nf !== g.exhausted)
				report_mismatch($sformatf("none_free %0b, predicted %0b", nf, g.exhausted));
		endtask
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [1:0]      op;
	logic [ID_W-1:0] release_id;
	logic            out_valid;
	logic            out_ready;
	logic [ID_W-1:0] granted_id;
	logic            none_free;

	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;

	alloc_tracker pool = new();

	two_ended_bitmap_id_allocator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.release_id (release_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.granted_id (granted_id),
		.none_free  (none_free)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				pool.check_word(granted_id, none_free);
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// called at a rising edge; returns at the edge where the word is taken
	task automatic send_word(input op_t o, input logic [ID_W-1:0] rid);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		release_id <= rid;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pool.note_word(o, rid);
	endtask

	initial begin
		int sent;
		int r;
		bit filling;
		int overfull;
		int drain_floor;

		in_valid = 1'b0;
		op = OP_NOP;
		release_id = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_NOP, 8'hA5);
		send_word(OP_ALLOC_NORMAL, 8'h00);
		send_word(OP_ALLOC_NORMAL, 8'hFF);
		send_word(OP_ALLOC_WINDOW, 8'h00);
		send_word(OP_ALLOC_WINDOW, 8'h5A);
		send_word(OP_RELEASE, NONE_ID);
		send_word(OP_RELEASE, 8'd1);
		// releasing a clear bit still moves the hint
		send_word(OP_RELEASE, 8'd1);
		send_word(OP_ALLOC_NORMAL, 8'h00);
		send_word(OP_RELEASE, ID_W'(WINDOW_FLOOR + 1));
		send_word(OP_ALLOC_WINDOW, 8'h00);
		send_word(OP_RELEASE, ID_W'(WINDOW_FLOOR));
		send_word(OP_ALLOC_NORMAL, 8'h00);
		send_word(OP_ALLOC_NORMAL, 8'h00);
		send_word(OP_RELEASE, 8'd128);
		send_word(OP_ALLOC_NORMAL, 8'h00);
		send_word(OP_RELEASE, 8'd0);
		send_word(OP_NOP, 8'h5A);
		send_word(OP_RELEASE, 8'd170);

		// fill the window range, then run the upward scan off its top
		send_word(OP_RELEASE, SCAN_TOP_ID);
		for (int k = 0; k <= WINDOW_VIEWS; k++)
			send_word(OP_ALLOC_WINDOW, ID_W'($urandom));
		send_word(OP_RELEASE, ID_W'(WINDOW_FLOOR));
		send_word(OP_ALLOC_NORMAL, 8'h00);
		send_word(OP_ALLOC_NORMAL, 8'h00);

		// alternate between filling the map past exhaustion and draining it
		sent = 0;
		filling = 1'b1;
		overfull = 0;
		drain_floor = 0;
		while (sent < RANDOM_WORDS) begin
			case ((sent / 75) % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 47;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 47;
				end
				default: begin
					idle_pct = 22;
					stall_pct = 22;
				end
			endcase
			r = $urandom_range(99);
			if (filling) begin
				if (r < 45)
					send_word(OP_ALLOC_NORMAL, ID_W'($urandom));
				else if (r < 85)
					send_word(OP_ALLOC_WINDOW, ID_W'($urandom));
				else if (r < 94)
					send_word(OP_RELEASE, pool.pick_taken());
				else if (r < 97)
					send_word(OP_RELEASE, ID_W'($urandom));
				else if (r < 99)
					send_word(OP_NOP, ID_W'($urandom));
				else
					send_word(OP_RELEASE, NONE_ID);
				if ($countones(pool.taken) == SCAN_TOP + 1)
					overfull++;
				if (overfull >= 12) begin
					filling = 1'b0;
					overfull = 0;
					drain_floor = $urandom_range(40);
				end
			end else begin
				if (r < 10)
					send_word(OP_ALLOC_NORMAL, ID_W'($urandom));
				else if (r < 20)
					send_word(OP_ALLOC_WINDOW, ID_W'($urandom));
				else if (r < 88)
					send_word(OP_RELEASE, pool.pick_taken());
				else if (r < 95)
					send_word(OP_RELEASE, ID_W'($urandom));
				else if (r < 98)
					send_word(OP_NOP, ID_W'($urandom));
				else
					send_word(OP_RELEASE, NONE_ID);
				if ($countones(pool.taken) <= drain_floor)
					filling = 1'b1;
			end
			sent++;
		end

		in_valid <= 1'b0;
		while (pool.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (pool.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tebia_pkg.sv
rtl/tebia_ram.sv
rtl/tebia_word_scan.sv
rtl/two_ended_bitmap_id_allocator.sv
rtl/tebia_checker.sv
tb/sv/testbench.sv
